// ===== rtl/core/tcwb_pkg.sv =====
// Shared types, constants and register indexes for the text cursor and bounding box block.
// No dependencies; every other file imports this package.
package tcwb_pkg;

  localparam int GLYPH_ENTRIES = 256;
  localparam int COORD_BITS    = 16;
  localparam int GLYPH_AW      = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
  localparam int EXT_W         = 18;
  localparam int WRAP_W        = ((COORD_BITS > EXT_W) ? COORD_BITS : EXT_W) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam logic [8:0] ENTRIES_LIM     = 9'(GLYPH_ENTRIES);
  localparam coord_t     BOX_LEAST_INIT  = coord_t'(32767);
  localparam coord_t     BOX_MOST_INIT   = '1;
  localparam logic [7:0] CHAR_LF         = 8'h0A;
  localparam logic [7:0] CHAR_CR         = 8'h0D;
  localparam logic [7:0] CLASSIC_W       = 8'd6;
  localparam logic [7:0] CLASSIC_H       = 8'd8;
  localparam int         MODE_WRAP_BIT   = 0;
  localparam int         MODE_PROP_BIT   = 1;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_CHAR  = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    CFG_LINE_START   = 3'd0,
    CFG_WINDOW_RIGHT = 3'd1,
    CFG_SCALE_X      = 3'd2,
    CFG_SCALE_Y      = 3'd3,
    CFG_MODE         = 3'd4,
    CFG_LINE_ADVANCE = 3'd5,
    CFG_FIRST_CODE   = 3'd6,
    CFG_LAST_CODE    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_START,
    KIND_NEWLINE,
    KIND_DRAW,
    KIND_ADVANCE
  } kind_e;

  typedef struct packed {
    coord_t      line_start_x;
    coord_t      window_right;
    logic [7:0]  scale_x;
    logic [7:0]  scale_y;
    logic [1:0]  mode;
    logic [7:0]  line_advance;
    logic [7:0]  first_code;
    logic [7:0]  last_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        width;
    logic [7:0]        height;
    logic [7:0]        advance;
    logic signed [7:0] x_offset;
    logic signed [7:0] y_offset;
  } glyph_t;

  typedef struct packed {
    func_e      func;
    logic [7:0] code;
    logic       hit;
    coord_t     start_x;
    coord_t     start_y;
  } s1_t;

  typedef struct packed {
    kind_e                   kind;
    coord_t                  start_x;
    coord_t                  start_y;
    logic signed [EXT_W-1:0] ext;
    coord_t                  off_x;
    coord_t                  off_y;
    coord_t                  size_x;
    coord_t                  size_y;
    coord_t                  adv_x;
    coord_t                  line_h;
  } s2_t;

  typedef struct packed {
    logic   clear;
    logic   draw;
    coord_t draw_x;
    coord_t draw_y;
    coord_t cur_x;
    coord_t cur_y;
    coord_t x1;
    coord_t y1;
    coord_t size_x;
    coord_t size_y;
  } s3_t;

endpackage

// ===== rtl/core/text_cursor_wrap_bounds.sv =====
// Top level of the text cursor and bounding box block: configuration registers and the
// four request stages. Depends on tcwb_pkg and the tcwb stage modules.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    func, code, start, glyph metrics
//   out      source     out_valid_o / out_stall_i  draw, position, cursor, box
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request is accepted per cycle while in_stall_o is low. A request passes through the
// registered glyph memory read, then the scaling, cursor and box stages, to the outputs.
// Reset clears the cursor to zero and the box to empty; the glyph memory is not cleared.
// An output stall holds the result register and backs up through occupied stages only.
module text_cursor_wrap_bounds
  import tcwb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  code_i,
  input  coord_t      start_x_i,
  input  coord_t      start_y_i,
  input  logic [7:0]  glyph_width_i,
  input  logic [7:0]  glyph_height_i,
  input  logic [7:0]  glyph_advance_i,
  input  logic signed [7:0] glyph_x_offset_i,
  input  logic signed [7:0] glyph_y_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        draw_o,
  output coord_t      draw_x_o,
  output coord_t      draw_y_o,
  output coord_t      cursor_x_out_o,
  output coord_t      cursor_y_out_o,
  output coord_t      box_min_x_o,
  output coord_t      box_min_y_o,
  output coord_t      box_max_x_o,
  output coord_t      box_max_y_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t   cfg_q;
  glyph_t load;
  logic   s1_valid, s1_stall;
  s1_t    s1_item;
  glyph_t s1_glyph;
  logic   s2_valid, s2_stall;
  s2_t    s2_item;
  logic   s3_valid, s3_stall;
  s3_t    s3_item;
  logic   s4_stall;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_start_x <= '0;
      cfg_q.window_right <= coord_t'(32767);
      cfg_q.scale_x      <= 8'd1;
      cfg_q.scale_y      <= 8'd1;
      cfg_q.mode         <= 2'd0;
      cfg_q.line_advance <= 8'd8;
      cfg_q.first_code   <= 8'd32;
      cfg_q.last_code    <= 8'd126;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_START:   cfg_q.line_start_x <= coord_t'(cfg_data_i);
        CFG_WINDOW_RIGHT: cfg_q.window_right <= coord_t'(cfg_data_i);
        CFG_SCALE_X:      cfg_q.scale_x      <= cfg_data_i[7:0];
        CFG_SCALE_Y:      cfg_q.scale_y      <= cfg_data_i[7:0];
        CFG_MODE:         cfg_q.mode         <= cfg_data_i[1:0];
        CFG_LINE_ADVANCE: cfg_q.line_advance <= cfg_data_i[7:0];
        CFG_FIRST_CODE:   cfg_q.first_code   <= cfg_data_i[7:0];
        CFG_LAST_CODE:    cfg_q.last_code    <= cfg_data_i[7:0];
        default: begin
          cfg_q.mode <= cfg_q.mode;
        end
      endcase
    end
  end

  assign load.width    = glyph_width_i;
  assign load.height   = glyph_height_i;
  assign load.advance  = glyph_advance_i;
  assign load.x_offset = glyph_x_offset_i;
  assign load.y_offset = glyph_y_offset_i;

  tcwb_glyph_store u_glyph_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .valid_i   (in_valid_i),
    .func_i    (func_e'(func_i)),
    .code_i    (code_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .load_i    (load),
    .stall_o   (s1_stall),
    .valid_o   (s1_valid),
    .item_o    (s1_item),
    .glyph_o   (s1_glyph),
    .stall_i   (s2_stall)
  );

  tcwb_metric_scale u_metric_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s1_valid),
    .item_i  (s1_item),
    .glyph_i (s1_glyph),
    .stall_o (s2_stall),
    .valid_o (s2_valid),
    .item_o  (s2_item),
    .stall_i (s3_stall)
  );

  tcwb_pen_stage u_pen_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (s2_valid),
    .item_i  (s2_item),
    .stall_o (s3_stall),
    .valid_o (s3_valid),
    .item_o  (s3_item),
    .stall_i (s4_stall)
  );

  tcwb_box_stage u_box_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s3_valid),
    .item_i      (s3_item),
    .stall_o     (s4_stall),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .draw_o      (draw_o),
    .draw_x_o    (draw_x_o),
    .draw_y_o    (draw_y_o),
    .cursor_x_o  (cursor_x_out_o),
    .cursor_y_o  (cursor_y_out_o),
    .box_min_x_o (box_min_x_o),
    .box_min_y_o (box_min_y_o),
    .box_max_x_o (box_max_x_o),
    .box_max_y_o (box_max_y_o)
  );

  assign in_stall_o = s1_stall;

  // Backpressure at the input can only come from a held result at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

// ===== rtl/core/tcwb_glyph_store.sv =====
// Glyph metrics memory with registered read, and the first request stage.
// Depends on tcwb_pkg.
module tcwb_glyph_store
  import tcwb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       valid_i,
  input  func_e      func_i,
  input  logic [7:0] code_i,
  input  coord_t     start_x_i,
  input  coord_t     start_y_i,
  input  glyph_t     load_i,
  output logic       stall_o,
  output logic       valid_o,
  output s1_t        item_o,
  output glyph_t     glyph_o,
  input  logic       stall_i
);

  glyph_t mem [GLYPH_ENTRIES];

  logic       valid_q;
  s1_t        item_q;
  glyph_t     rd_q;
  logic       take;
  logic [7:0] idx;
  logic       hit;
  logic       wr_en;
  logic       rd_en;

  assign stall_o = valid_q && stall_i;
  assign take    = valid_i && !stall_o;
  assign idx     = code_i - cfg_i.first_code;
  assign hit     = (code_i >= cfg_i.first_code) && (code_i <= cfg_i.last_code) &&
                   ({1'b0, idx} < ENTRIES_LIM);
  assign wr_en   = take && (func_i == FUNC_LOAD) && ({1'b0, code_i} < ENTRIES_LIM);
  assign rd_en   = take && (func_i == FUNC_CHAR);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[code_i[GLYPH_AW-1:0]] <= load_i;
    end
    if (rd_en) begin
      rd_q <= mem[idx[GLYPH_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func    <= func_i;
      item_q.code    <= code_i;
      item_q.hit     <= hit;
      item_q.start_x <= start_x_i;
      item_q.start_y <= start_y_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign glyph_o = rd_q;

endmodule

// ===== rtl/core/tcwb_metric_scale.sv =====
// Request decode and scaling of glyph or classic cell metrics by the magnification factors.
// Depends on tcwb_pkg.
module tcwb_metric_scale
  import tcwb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  input  s1_t    item_i,
  input  glyph_t glyph_i,
  output logic   stall_o,
  output logic   valid_o,
  output s2_t    item_o,
  input  logic   stall_i
);

  logic            valid_q;
  s2_t             item_q;
  s2_t             item_d;
  logic            take;
  logic            prop;
  logic [9:0]      xw;
  logic [EXT_W-1:0] ext_u;
  logic [COORD_BITS-1:0] sx_c;
  logic [COORD_BITS-1:0] sy_c;

  assign stall_o = valid_q && stall_i;
  assign take    = valid_i && !stall_o;
  assign prop    = cfg_i.mode[MODE_PROP_BIT];
  assign sx_c    = {{(COORD_BITS-8){1'b0}}, cfg_i.scale_x};
  assign sy_c    = {{(COORD_BITS-8){1'b0}}, cfg_i.scale_y};
  assign xw      = {{2{glyph_i.x_offset[7]}}, glyph_i.x_offset} + {2'b00, glyph_i.width};
  assign ext_u   = {{(EXT_W-10){xw[9]}}, xw} * {{(EXT_W-8){1'b0}}, cfg_i.scale_x};

  always_comb begin
    item_d         = '0;
    item_d.start_x = item_i.start_x;
    item_d.start_y = item_i.start_y;
    item_d.line_h  = sy_c * {{(COORD_BITS-8){1'b0}},
                             (prop ? cfg_i.line_advance : CLASSIC_H)};
    case (item_i.func)
      FUNC_START: begin
        item_d.kind = KIND_START;
      end
      FUNC_CHAR: begin
        if (item_i.code == CHAR_LF) begin
          item_d.kind = KIND_NEWLINE;
        end else if (item_i.code == CHAR_CR) begin
          item_d.kind = KIND_NONE;
        end else if (!prop) begin
          item_d.kind = KIND_DRAW;
        end else if (!item_i.hit) begin
          item_d.kind = KIND_NONE;
        end else if (glyph_i.width != 8'd0 && glyph_i.height != 8'd0) begin
          item_d.kind = KIND_DRAW;
        end else begin
          item_d.kind = KIND_ADVANCE;
        end
      end
      default: begin
        item_d.kind = KIND_NONE;
      end
    endcase
    if (prop) begin
      item_d.ext    = $signed(ext_u);
      item_d.off_x  = $signed({{(COORD_BITS-8){glyph_i.x_offset[7]}}, glyph_i.x_offset} * sx_c);
      item_d.off_y  = $signed({{(COORD_BITS-8){glyph_i.y_offset[7]}}, glyph_i.y_offset} * sy_c);
      item_d.size_x = $signed({{(COORD_BITS-8){1'b0}}, glyph_i.width} * sx_c);
      item_d.size_y = $signed({{(COORD_BITS-8){1'b0}}, glyph_i.height} * sy_c);
      item_d.adv_x  = $signed({{(COORD_BITS-8){1'b0}}, glyph_i.advance} * sx_c);
    end else begin
      item_d.ext    = $signed({{(EXT_W-8){1'b0}}, cfg_i.scale_x} *
                              {{(EXT_W-8){1'b0}}, CLASSIC_W});
      item_d.off_x  = '0;
      item_d.off_y  = '0;
      item_d.size_x = $signed(sx_c * {{(COORD_BITS-8){1'b0}}, CLASSIC_W});
      item_d.size_y = $signed(sy_c * {{(COORD_BITS-8){1'b0}}, CLASSIC_H});
      item_d.adv_x  = $signed(sx_c * {{(COORD_BITS-8){1'b0}}, CLASSIC_W});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/tcwb_pen_stage.sv =====
// Text cursor register with the wrap test, newline handling and draw position.
// Depends on tcwb_pkg.
module tcwb_pen_stage
  import tcwb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  input  s2_t  item_i,
  output logic stall_o,
  output logic valid_o,
  output s3_t  item_o,
  input  logic stall_i
);

  logic                     valid_q;
  s3_t                      item_q;
  s3_t                      item_d;
  logic                     take;
  coord_t                   pen_x_q;
  coord_t                   pen_y_q;
  coord_t                   pen_x_d;
  coord_t                   pen_y_d;
  logic signed [WRAP_W-1:0] wrap_sum;
  logic signed [WRAP_W-1:0] wrap_lim;
  logic                     do_wrap;
  coord_t                   next_line_y;
  coord_t                   base_x;
  coord_t                   base_y;

  assign stall_o = valid_q && stall_i;
  assign take    = valid_i && !stall_o;

  always_comb begin
    wrap_sum    = WRAP_W'(pen_x_q) + WRAP_W'(item_i.ext);
    wrap_lim    = WRAP_W'(cfg_i.window_right);
    do_wrap     = cfg_i.mode[MODE_WRAP_BIT] && (item_i.kind == KIND_DRAW) &&
                  (wrap_sum > wrap_lim);
    next_line_y = pen_y_q + item_i.line_h;
    base_x      = do_wrap ? cfg_i.line_start_x : pen_x_q;
    base_y      = do_wrap ? next_line_y : pen_y_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    case (item_i.kind)
      KIND_START: begin
        pen_x_d = item_i.start_x;
        pen_y_d = item_i.start_y;
      end
      KIND_NEWLINE: begin
        pen_x_d = cfg_i.line_start_x;
        pen_y_d = next_line_y;
      end
      KIND_DRAW: begin
        pen_x_d = base_x + item_i.adv_x;
        pen_y_d = base_y;
      end
      KIND_ADVANCE: begin
        pen_x_d = pen_x_q + item_i.adv_x;
      end
      default: begin
        pen_x_d = pen_x_q;
      end
    endcase
    item_d.clear  = (item_i.kind == KIND_START);
    item_d.draw   = (item_i.kind == KIND_DRAW);
    item_d.draw_x = item_d.draw ? base_x : '0;
    item_d.draw_y = item_d.draw ? base_y : '0;
    item_d.cur_x  = pen_x_d;
    item_d.cur_y  = pen_y_d;
    item_d.x1     = base_x + item_i.off_x;
    item_d.y1     = base_y + item_i.off_y;
    item_d.size_x = item_i.size_x;
    item_d.size_y = item_i.size_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pen_x_q <= '0;
      pen_y_q <= '0;
    end else begin
      if (!stall_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        pen_x_q <= pen_x_d;
        pen_y_q <= pen_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // A request that neither places, advances nor draws leaves the cursor alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (item_i.kind == KIND_NONE) |=> $stable(pen_x_q) && $stable(pen_y_q))
    else $error("cursor moved on a request without effect");

endmodule

// ===== rtl/core/tcwb_box_stage.sv =====
// Bounding box registers and the output register of the result channel.
// Depends on tcwb_pkg.
module tcwb_box_stage
  import tcwb_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  s3_t    item_i,
  output logic   stall_o,
  output logic   valid_o,
  input  logic   stall_i,
  output logic   draw_o,
  output coord_t draw_x_o,
  output coord_t draw_y_o,
  output coord_t cursor_x_o,
  output coord_t cursor_y_o,
  output coord_t box_min_x_o,
  output coord_t box_min_y_o,
  output coord_t box_max_x_o,
  output coord_t box_max_y_o
);

  logic   valid_q;
  logic   take;
  logic   draw_q;
  coord_t draw_x_q;
  coord_t draw_y_q;
  coord_t cur_x_q;
  coord_t cur_y_q;
  coord_t least_x_q, least_x_d;
  coord_t least_y_q, least_y_d;
  coord_t most_x_q, most_x_d;
  coord_t most_y_q, most_y_d;
  coord_t x2;
  coord_t y2;

  assign stall_o = valid_q && stall_i;
  assign take    = valid_i && !stall_o;

  always_comb begin
    x2        = item_i.x1 + item_i.size_x - coord_t'(1);
    y2        = item_i.y1 + item_i.size_y - coord_t'(1);
    least_x_d = least_x_q;
    least_y_d = least_y_q;
    most_x_d  = most_x_q;
    most_y_d  = most_y_q;
    if (item_i.clear) begin
      least_x_d = BOX_LEAST_INIT;
      least_y_d = BOX_LEAST_INIT;
      most_x_d  = BOX_MOST_INIT;
      most_y_d  = BOX_MOST_INIT;
    end else if (item_i.draw) begin
      if (item_i.x1 < least_x_q) begin
        least_x_d = item_i.x1;
      end
      if (item_i.y1 < least_y_q) begin
        least_y_d = item_i.y1;
      end
      if (x2 > most_x_q) begin
        most_x_d = x2;
      end
      if (y2 > most_y_q) begin
        most_y_d = y2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      least_x_q <= BOX_LEAST_INIT;
      least_y_q <= BOX_LEAST_INIT;
      most_x_q  <= BOX_MOST_INIT;
      most_y_q  <= BOX_MOST_INIT;
    end else begin
      if (!stall_o) begin
        valid_q <= valid_i;
      end
      if (take) begin
        least_x_q <= least_x_d;
        least_y_q <= least_y_d;
        most_x_q  <= most_x_d;
        most_y_q  <= most_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      draw_q   <= item_i.draw;
      draw_x_q <= item_i.draw_x;
      draw_y_q <= item_i.draw_y;
      cur_x_q  <= item_i.cur_x;
      cur_y_q  <= item_i.cur_y;
    end
  end

  assign valid_o     = valid_q;
  assign draw_o      = draw_q;
  assign draw_x_o    = draw_x_q;
  assign draw_y_o    = draw_y_q;
  assign cursor_x_o  = cur_x_q;
  assign cursor_y_o  = cur_y_q;
  assign box_min_x_o = least_x_q;
  assign box_min_y_o = least_y_q;
  assign box_max_x_o = most_x_q;
  assign box_max_y_o = most_y_q;

  // A start request leaves the box empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.clear |=> (least_x_q == BOX_LEAST_INIT) && (least_y_q == BOX_LEAST_INIT) &&
                             (most_x_q == BOX_MOST_INIT) && (most_y_q == BOX_MOST_INIT))
    else $error("box not cleared by start request");

  // The box always covers the top left corner of a drawn character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_i.draw && !item_i.clear |=>
      (least_x_q <= $past(item_i.x1)) && (least_y_q <= $past(item_i.y1)))
    else $error("box misses a drawn character");

  // A result that draws nothing reports a zero draw position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !draw_q |-> (draw_x_q == '0) && (draw_y_q == '0))
    else $error("draw position set without a draw");

endmodule

// ===== bench/text_cursor_wrap_bounds_tb.sv =====
// Self-checking bench for text_cursor_wrap_bounds: directed font and glyph-table cases, then
// random settings and request streams. Depends on tcwb_pkg and the block's RTL, nothing else.
module text_cursor_wrap_bounds_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcwb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 23;

  typedef struct {
    func_e             func;
    logic [7:0]        code;
    coord_t            start_x;
    coord_t            start_y;
    logic [7:0]        width;
    logic [7:0]        height;
    logic [7:0]        advance;
    logic signed [7:0] x_off;
    logic signed [7:0] y_off;
  } req_t;

  typedef struct packed {
    logic   draw;
    coord_t draw_x;
    coord_t draw_y;
    coord_t cur_x;
    coord_t cur_y;
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } layout_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid = 1'b0;
  logic [1:0]        func_d = '0;
  logic [7:0]        code_d = '0;
  coord_t            start_x_d = '0;
  coord_t            start_y_d = '0;
  logic [7:0]        width_d = '0;
  logic [7:0]        height_d = '0;
  logic [7:0]        advance_d = '0;
  logic signed [7:0] x_off_d = '0;
  logic signed [7:0] y_off_d = '0;
  logic              out_stall = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  logic   in_stall_o, out_valid_o, draw_o, cfg_ready_o;
  coord_t draw_x_o, draw_y_o, cursor_x_out_o, cursor_y_out_o;
  coord_t box_min_x_o, box_min_y_o, box_max_x_o, box_max_y_o;

  text_cursor_wrap_bounds dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .func_i           (func_d),
    .code_i           (code_d),
    .start_x_i        (start_x_d),
    .start_y_i        (start_y_d),
    .glyph_width_i    (width_d),
    .glyph_height_i   (height_d),
    .glyph_advance_i  (advance_d),
    .glyph_x_offset_i (x_off_d),
    .glyph_y_offset_i (y_off_d),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .draw_o           (draw_o),
    .draw_x_o         (draw_x_o),
    .draw_y_o         (draw_y_o),
    .cursor_x_out_o   (cursor_x_out_o),
    .cursor_y_out_o   (cursor_y_out_o),
    .box_min_x_o      (box_min_x_o),
    .box_min_y_o      (box_min_y_o),
    .box_max_x_o      (box_max_x_o),
    .box_max_y_o      (box_max_y_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  int cycle_cnt = 0;
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL text_cursor_wrap_bounds");
    $finish;
  end

  // Predictor state: settings, pen, box and glyph table.
  int cfg_line_start = 0;
  int cfg_win_right  = 32767;
  int cfg_scale_x    = 1;
  int cfg_scale_y    = 1;
  logic [1:0] cfg_mode = '0;
  int cfg_line_adv   = 8;
  int cfg_first      = 32;
  int cfg_last       = 126;

  int pen_x = 0, pen_y = 0;
  int least_x = 32767, least_y = 32767, most_x = -1, most_y = -1;
  int g_w[GLYPH_ENTRIES], g_h[GLYPH_ENTRIES], g_adv[GLYPH_ENTRIES];
  int g_xo[GLYPH_ENTRIES], g_yo[GLYPH_ENTRIES];
  bit glyph_written[GLYPH_ENTRIES];

  layout_t layout_q[$];
  bit jitter = 1'b1;
  int mismatches = 0;
  int results_seen = 0;
  int drawn_seen = 0;

  function automatic int wrap16(int v);
    coord_t t;
    t = coord_t'(v);
    return int'(t);
  endfunction

  function automatic void grow_box(int x1, int y1, int x2, int y2);
    x1 = wrap16(x1);
    y1 = wrap16(y1);
    x2 = wrap16(x2);
    y2 = wrap16(y2);
    if (x1 < least_x) least_x = x1;
    if (y1 < least_y) least_y = y1;
    if (x2 > most_x) most_x = x2;
    if (y2 > most_y) most_y = y2;
  endfunction

  function automatic layout_t layout_step(req_t r);
    layout_t o;
    int lh, ext, idx, x1, y1, dx, dy;
    bit wrap_on, prop, drawn;
    wrap_on = cfg_mode[MODE_WRAP_BIT];
    prop = cfg_mode[MODE_PROP_BIT];
    lh = prop ? cfg_scale_y * cfg_line_adv : cfg_scale_y * 8;
    drawn = 1'b0;
    dx = 0;
    dy = 0;
    case (r.func)
      FUNC_START: begin
        pen_x = wrap16(int'(r.start_x));
        pen_y = wrap16(int'(r.start_y));
        least_x = int'(BOX_LEAST_INIT);
        least_y = int'(BOX_LEAST_INIT);
        most_x = int'(BOX_MOST_INIT);
        most_y = int'(BOX_MOST_INIT);
      end
      FUNC_LOAD: begin
        idx = int'(r.code);
        if (idx < GLYPH_ENTRIES) begin
          g_w[idx] = int'(r.width);
          g_h[idx] = int'(r.height);
          g_adv[idx] = int'(r.advance);
          g_xo[idx] = int'(r.x_off);
          g_yo[idx] = int'(r.y_off);
          glyph_written[idx] = 1'b1;
        end
      end
      FUNC_CHAR: begin
        if (r.code == CHAR_LF) begin
          pen_x = wrap16(cfg_line_start);
          pen_y = wrap16(pen_y + lh);
        end else if (r.code == CHAR_CR) begin
        end else if (!prop) begin
          ext = cfg_scale_x * 6;
          if (wrap_on && pen_x + ext > cfg_win_right) begin
            pen_x = wrap16(cfg_line_start);
            pen_y = wrap16(pen_y + lh);
          end
          drawn = 1'b1;
          dx = pen_x;
          dy = pen_y;
          grow_box(pen_x, pen_y, pen_x + ext - 1, pen_y + cfg_scale_y * 8 - 1);
          pen_x = wrap16(pen_x + ext);
        end else if (int'(r.code) >= cfg_first && int'(r.code) <= cfg_last &&
                     int'(r.code) - cfg_first < GLYPH_ENTRIES) begin
          idx = int'(r.code) - cfg_first;
          if (g_w[idx] > 0 && g_h[idx] > 0) begin
            if (wrap_on && pen_x + cfg_scale_x * (g_xo[idx] + g_w[idx]) > cfg_win_right) begin
              pen_x = wrap16(cfg_line_start);
              pen_y = wrap16(pen_y + lh);
            end
            drawn = 1'b1;
            dx = pen_x;
            dy = pen_y;
            x1 = wrap16(pen_x + g_xo[idx] * cfg_scale_x);
            y1 = wrap16(pen_y + g_yo[idx] * cfg_scale_y);
            grow_box(x1, y1, x1 + g_w[idx] * cfg_scale_x - 1, y1 + g_h[idx] * cfg_scale_y - 1);
          end
          pen_x = wrap16(pen_x + g_adv[idx] * cfg_scale_x);
        end
      end
      default: begin
      end
    endcase
    o.draw = drawn;
    o.draw_x = coord_t'(dx);
    o.draw_y = coord_t'(dy);
    o.cur_x = coord_t'(pen_x);
    o.cur_y = coord_t'(pen_y);
    o.min_x = coord_t'(least_x);
    o.min_y = coord_t'(least_y);
    o.max_x = coord_t'(most_x);
    o.max_y = coord_t'(most_y);
    return o;
  endfunction

  task automatic cmp_field(string fname, int e, int a);
    if (e != a) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, fname, e, a);
    end
  endtask

  task automatic check_layout();
    layout_t e;
    results_seen++;
    if (draw_o) drawn_seen++;
    if (layout_q.size() == 0) begin
      mismatches++;
      $display("%0t ns: result with no request waiting", $time);
      return;
    end
    e = layout_q.pop_front();
    cmp_field("draw", int'(e.draw), int'(draw_o));
    cmp_field("draw_x", int'(e.draw_x), int'(draw_x_o));
    cmp_field("draw_y", int'(e.draw_y), int'(draw_y_o));
    cmp_field("cur_x", int'(e.cur_x), int'(cursor_x_out_o));
    cmp_field("cur_y", int'(e.cur_y), int'(cursor_y_out_o));
    cmp_field("box_min_x", int'(e.min_x), int'(box_min_x_o));
    cmp_field("box_min_y", int'(e.min_y), int'(box_min_y_o));
    cmp_field("box_max_x", int'(e.max_x), int'(box_max_x_o));
    cmp_field("box_max_y", int'(e.max_y), int'(box_max_y_o));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) check_layout();
    out_stall <= jitter && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_req(req_t r);
    if (cfg_valid) cfg_valid <= 1'b0;
    if (jitter && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid <= 1'b1;
    func_d <= r.func;
    code_d <= r.code;
    start_x_d <= r.start_x;
    start_y_d <= r.start_y;
    width_d <= r.width;
    height_d <= r.height;
    advance_d <= r.advance;
    x_off_d <= r.x_off;
    y_off_d <= r.y_off;
    do @(posedge clk_i); while (in_stall_o);
    layout_q.push_back(layout_step(r));
  endtask

  function automatic req_t noise_req(func_e f, logic [7:0] c);
    req_t r;
    r.func = f;
    r.code = c;
    r.start_x = coord_t'($urandom);
    r.start_y = coord_t'($urandom);
    r.width = 8'($urandom);
    r.height = 8'($urandom);
    r.advance = 8'($urandom);
    r.x_off = 8'($urandom);
    r.y_off = 8'($urandom);
    return r;
  endfunction

  task automatic put_start(coord_t x, coord_t y);
    req_t r;
    r = noise_req(FUNC_START, 8'($urandom));
    r.start_x = x;
    r.start_y = y;
    send_req(r);
  endtask

  task automatic put_char(logic [7:0] c);
    send_req(noise_req(FUNC_CHAR, c));
  endtask

  task automatic put_nop();
    send_req(noise_req(FUNC_NOP, 8'($urandom)));
  endtask

  task automatic put_load(logic [7:0] idx, logic [7:0] w, logic [7:0] h, logic [7:0] adv,
                          logic signed [7:0] xo, logic signed [7:0] yo);
    req_t r;
    r = noise_req(FUNC_LOAD, idx);
    r.width = w;
    r.height = h;
    r.advance = adv;
    r.x_off = xo;
    r.y_off = yo;
    send_req(r);
  endtask

  task automatic put_random_load(logic [7:0] idx);
    logic [7:0] w, h, adv;
    logic signed [7:0] xo, yo;
    w = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
    h = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
    adv = 8'($urandom_range(0, 10));
    xo = 8'(int'($urandom_range(0, 6)) - 3);
    yo = 8'(int'($urandom_range(0, 6)) - 3);
    if ($urandom_range(9) == 0) begin
      w = 8'($urandom);
      h = 8'($urandom);
      adv = 8'($urandom);
    end
    if ($urandom_range(7) == 0) begin
      xo = 8'($urandom);
      yo = 8'($urandom);
    end
    put_load(idx, w, h, adv, xo, yo);
  endtask

  // A glyph entry is loaded before the first character that reads it.
  task automatic put_layout_char(logic [7:0] c);
    int idx;
    idx = int'(c) - cfg_first;
    if (cfg_mode[MODE_PROP_BIT] && c != CHAR_LF && c != CHAR_CR &&
        int'(c) >= cfg_first && int'(c) <= cfg_last && !glyph_written[idx])
      put_random_load(8'(idx));
    put_char(c);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LINE_START:   cfg_line_start = int'($signed(data));
      CFG_WINDOW_RIGHT: cfg_win_right = int'($signed(data));
      CFG_SCALE_X:      cfg_scale_x = int'(data[7:0]);
      CFG_SCALE_Y:      cfg_scale_y = int'(data[7:0]);
      CFG_MODE:         cfg_mode = data[1:0];
      CFG_LINE_ADVANCE: cfg_line_adv = int'(data[7:0]);
      CFG_FIRST_CODE:   cfg_first = int'(data[7:0]);
      CFG_LAST_CODE:    cfg_last = int'(data[7:0]);
      default: begin
      end
    endcase
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic test_classic_font();
    put_nop();
    put_char(8'h41);
    put_start(16'sh7FFF, 16'sh8000);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_LF);
    put_char(CHAR_CR);
    settle();
    write_reg(CFG_WINDOW_RIGHT, 16'd10);
    write_reg(CFG_SCALE_X, 16'd255);
    write_reg(CFG_SCALE_Y, 16'd255);
    write_reg(CFG_LINE_START, 16'h8000);
    write_reg(CFG_MODE, 16'd1);
    put_start(16'sd5, 16'sh7FFF);
    put_char(8'h41);
    put_char(8'h42);
    settle();
    write_reg(CFG_SCALE_X, 16'd0);
    write_reg(CFG_SCALE_Y, 16'd0);
    put_char(8'h43);
  endtask

  task automatic test_glyph_table();
    settle();
    write_reg(CFG_LINE_START, 16'd0);
    write_reg(CFG_WINDOW_RIGHT, 16'd200);
    write_reg(CFG_SCALE_X, 16'd1);
    write_reg(CFG_SCALE_Y, 16'd1);
    write_reg(CFG_MODE, 16'd3);
    write_reg(CFG_LINE_ADVANCE, 16'd255);
    write_reg(CFG_FIRST_CODE, 16'd0);
    write_reg(CFG_LAST_CODE, 16'd255);
    put_load(8'd0, 8'd255, 8'd255, 8'd255, 8'sd127, -8'sd128);
    put_load(8'd1, 8'd0, 8'd5, 8'd3, 8'sd0, 8'sd0);
    put_load(8'd2, 8'd4, 8'd0, 8'd7, 8'sd1, 8'sd1);
    put_load(8'd3, 8'd1, 8'd1, 8'd0, -8'sd128, 8'sd127);
    put_start(16'sd150, 16'sh8000);
    put_char(8'd0);
    put_char(8'd3);
    put_char(8'd1);
    put_char(8'd2);
    put_char(CHAR_LF);
    put_char(CHAR_CR);
    settle();
    write_reg(CFG_FIRST_CODE, 16'd1);
    write_reg(CFG_LAST_CODE, 16'd3);
    put_char(8'd0);
    put_char(8'd3);
  endtask

  task automatic test_random_layout(int phase, int n_items);
    int ls, wr, sc_x, sc_y, la, fc, lc, done, pick, c;
    settle();
    jitter = (phase >= 3);
    ls = int'(coord_t'($urandom));
    wr = ls + int'($urandom_range(20, 400));
    sc_x = ($urandom_range(7) == 0) ? int'($urandom_range(1, 255)) : int'($urandom_range(1, 3));
    sc_y = ($urandom_range(7) == 0) ? int'($urandom_range(1, 255)) : int'($urandom_range(1, 3));
    la = int'($urandom_range(0, 255));
    fc = int'($urandom_range(0, 96));
    lc = fc + int'($urandom_range(0, 159));
    if (lc > 255) lc = 255;
    if ($urandom_range(5) == 0) lc = int'($urandom_range(0, fc));
    if (phase == 4) begin
      ls = -32768;
      wr = 32767;
      sc_x = 255;
      sc_y = 255;
      la = 255;
      fc = 0;
      lc = 255;
    end else if (phase == 5) begin
      ls = 32767;
      wr = -32768;
      sc_x = 1;
      sc_y = 1;
      la = 0;
      fc = 255;
      lc = 0;
    end
    write_reg(CFG_LINE_START, 16'(ls));
    write_reg(CFG_WINDOW_RIGHT, 16'(wr));
    write_reg(CFG_SCALE_X, 16'(sc_x));
    write_reg(CFG_SCALE_Y, 16'(sc_y));
    write_reg(CFG_MODE, 16'(phase % 4));
    write_reg(CFG_LINE_ADVANCE, 16'(la));
    write_reg(CFG_FIRST_CODE, 16'(fc));
    write_reg(CFG_LAST_CODE, 16'(lc));
    put_start(coord_t'(cfg_line_start + int'($urandom_range(0, 60))), coord_t'($urandom));
    done = 0;
    while (done < n_items) begin
      pick = int'($urandom_range(99));
      if (pick < 4) begin
        if ($urandom_range(2) == 0) put_start(coord_t'($urandom), coord_t'($urandom));
        else put_start(coord_t'(cfg_line_start + int'($urandom_range(0, 60))),
                       coord_t'($urandom));
        done++;
      end else if (pick < 12) begin
        put_random_load(8'($urandom));
        done++;
      end else if (pick < 14) begin
        put_nop();
      end else if (pick < 20) begin
        put_char(CHAR_LF);
        done++;
      end else if (pick < 23) begin
        put_char(CHAR_CR);
      end else begin
        if (cfg_mode[MODE_PROP_BIT] && cfg_first <= cfg_last && $urandom_range(9) != 0)
          c = int'($urandom_range(cfg_first, cfg_last));
        else
          c = int'($urandom_range(0, 255));
        put_layout_char(8'(c));
        done++;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_classic_font();
    test_glyph_table();
    for (int p = 0; p < 12; p++) test_random_layout(p, 115);
    settle();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d results, %0d of them drawn characters, over the directed font",
             results_seen, drawn_seen);
    $display("and glyph-table cases and twelve random settings of all eight registers.");
    if (mismatches == 0 && layout_q.size() == 0) begin
      $display("PASS text_cursor_wrap_bounds");
    end else begin
      $display("FAIL text_cursor_wrap_bounds");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tcwb_pkg.sv
rtl/core/tcwb_glyph_store.sv
rtl/core/tcwb_metric_scale.sv
rtl/core/tcwb_pen_stage.sv
rtl/core/tcwb_box_stage.sv
rtl/core/text_cursor_wrap_bounds.sv
bench/text_cursor_wrap_bounds_tb.sv
